@@ hw/rtl/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned KEY_CHARS   = 8;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned SIZE_W      = ADDR_W + 1;
  localparam int unsigned KEY_W       = 8 * KEY_CHARS;
  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DIVISOR_W   = 16;

  localparam logic [12:0] TABLE_SIZE_RST   = 13'd11;
  localparam logic [15:0] DOUBLE_PRIME_RST = 16'd10007;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_ALT    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PROBE_LINEAR = 2'd0,
    PROBE_QUAD   = 2'd1,
    PROBE_DOUBLE = 2'd2,
    PROBE_ALT    = 2'd3
  } probe_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_MISSING  = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_HASH_MODE    = 2'd0,
    REG_PROBE_MODE   = 2'd1,
    REG_TABLE_SIZE   = 2'd2,
    REG_DOUBLE_PRIME = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] slot_index;
    logic [12:0] probe_count;
    logic [2:0]  status;
    logic [31:0] found_value;
  } out_item_t;

  typedef struct packed {
    logic              occupied;
    logic [3:0]        key_length;
    logic [KEY_W-1:0]  key;
    logic [31:0]       value;
  } slot_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

@@ hw/rtl/oaht_ram.sv @@
// ----------------------------------------------------------------------------
// oaht_ram
// Single write port, single read port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/oaht_div.sv @@
// ----------------------------------------------------------------------------
// oaht_div
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module oaht_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  oaht_pkg::div_req_t              req_i,
  output logic                            done_o,
  output logic [oaht_pkg::DIVISOR_W-1:0]  rem_o
);
  import oaht_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIVISOR_W:0]   trial;

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[DIV_W-1]};
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIVISOR_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
      dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/open_addressing_hash_table.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Closed hash table with byte-sum or shift-by-five hash and linear,
// quadratic or double-hashing probe sequences over one slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request item:
//   insert, search or clear. Output channel (out_valid_o / out_stall_i)
//   returns one result item per request. Config writes (cfg_valid_i,
//   cfg_ready_o) set hash_mode, probe_mode, table_size, double_prime; the
//   user must issue them only while the block is idle, which the block
//   itself does not enforce. An insert/search hashes the key bytes,
//   reduces the hash by the table size in the divider, runs two more
//   divisions in double-hashing mode, then takes a read state and a
//   compare state per probe over the registered slot RAM read, and loads
//   the result. A clear sweeps all 4096 slots, one per cycle. One item
//   is in work at a time. After reset the same sweep runs; no item is
//   accepted until it ends. A finished result waits in the output register
//   while the receiver stalls; a new item may be taken meanwhile, but its
//   result is held back until the previous one has been taken.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  oaht_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output oaht_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import oaht_pkg::*;

  typedef enum logic [9:0] {
    S_INIT = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_HASH = 10'b0000000100,
    S_MOD1 = 10'b0000001000,
    S_MOD2 = 10'b0000010000,
    S_MOD3 = 10'b0000100000,
    S_RD   = 10'b0001000000,
    S_CMP  = 10'b0010000000,
    S_CLR  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic        hash_mode_q;
  logic [1:0]  probe_mode_q;
  logic [12:0] table_size_q;
  logic [15:0] double_prime_q;

  logic [1:0]        act_q, act_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [3:0]        len_q, len_d;
  logic [31:0]       val_q, val_d;
  logic [3:0]        k_q, k_d;
  logic [31:0]       acc_q, acc_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] inc_q, inc_d;
  logic [SIZE_W-1:0] j_q, j_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [SIZE_W-1:0]    size_eff;
  logic [15:0]          prime_eff;
  logic [KEY_W-1:0]     key_mask;
  logic [3:0]           len_sat;
  logic [7:0]           cur_byte;
  logic [ADDR_W-1:0]    inc_one;
  logic [SIZE_W:0]      pos_sum;
  logic [SIZE_W:0]      quad_sum;
  logic [SIZE_W:0]      quad_sum2;
  logic [15:0]          dstep;
  probe_e               pmode;

  div_req_t             div_req;
  logic                 div_done;
  logic [DIVISOR_W-1:0] div_rem;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  slot_t             mem_rdata;
  logic [SLOT_W-1:0] mem_rbits;

  oaht_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  oaht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (pos_q),
    .rdata_o (mem_rbits)
  );

  assign mem_rdata = slot_t'(mem_rbits);

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q    <= 1'b0;
      probe_mode_q   <= PROBE_LINEAR;
      table_size_q   <= TABLE_SIZE_RST;
      double_prime_q <= DOUBLE_PRIME_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_HASH_MODE:    hash_mode_q    <= cfg_data_i[0];
        REG_PROBE_MODE:   probe_mode_q   <= cfg_data_i[1:0];
        REG_TABLE_SIZE:   table_size_q   <= cfg_data_i[12:0];
        REG_DOUBLE_PRIME: double_prime_q <= cfg_data_i;
        default:          hash_mode_q    <= hash_mode_q;
      endcase
    end
  end

  always_comb begin
    if (table_size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (table_size_q > 13'(TABLE_DEPTH)) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = SIZE_W'(table_size_q);
    end
    prime_eff = (double_prime_q == '0) ? 16'd1 : double_prime_q;
    pmode     = probe_e'(probe_mode_q);
  end

  always_comb begin
    len_sat  = (in_data_i.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS)
                                                       : in_data_i.key_length;
    key_mask = '0;
    for (int b = 0; b < KEY_CHARS; b++) begin
      if (4'(b) < len_sat) begin
        key_mask[8*b +: 8] = 8'hFF;
      end
    end
  end

  assign cur_byte  = key_q[8*k_q[2:0] +: 8];
  assign inc_one   = (size_eff == SIZE_W'(1)) ? '0 : ADDR_W'(1);
  assign pos_sum   = {2'b00, pos_q} + {2'b00, inc_q};
  assign quad_sum  = {2'b00, inc_q} + (SIZE_W + 1)'(2);
  assign quad_sum2 = (quad_sum >= {1'b0, size_eff}) ? quad_sum - {1'b0, size_eff}
                                                     : quad_sum;
  assign dstep     = prime_eff - div_rem;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    len_d       = len_q;
    val_d       = val_q;
    k_d         = k_q;
    acc_d       = acc_q;
    start_d     = start_q;
    pos_d       = pos_q;
    inc_d       = inc_q;
    j_d         = j_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_req     = '0;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT, S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          if (state_q == S_INIT) begin
            state_d = S_IDLE;
          end else begin
            res_d   = '0;
            res_d.status = ST_CLEARED;
            state_d = S_DONE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action;
          key_d = in_data_i.key_bytes & key_mask;
          len_d = len_sat;
          val_d = in_data_i.entry_value;
          acc_d = {24'd0, in_data_i.key_bytes[7:0] & key_mask[7:0]};
          k_d   = 4'd1;
          clr_d = '0;
          if (action_e'(in_data_i.action) == ACT_CLEAR) begin
            state_d = S_CLR;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (k_q < len_q) begin
          if (hash_mode_q) begin
            acc_d = {acc_q[26:0], 5'd0} + {24'd0, cur_byte};
          end else begin
            acc_d = acc_q + {24'd0, cur_byte};
          end
          k_d = k_q + 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = acc_q;
          div_req.divisor  = DIVISOR_W'(size_eff);
          state_d          = S_MOD1;
        end
      end
      S_MOD1: begin
        if (div_done) begin
          start_d = div_rem[ADDR_W-1:0];
          pos_d   = div_rem[ADDR_W-1:0];
          j_d     = '0;
          inc_d   = inc_one;
          if (pmode == PROBE_DOUBLE) begin
            div_req.start    = 1'b1;
            div_req.dividend = {{(DIV_W-ADDR_W){1'b0}}, div_rem[ADDR_W-1:0]};
            div_req.divisor  = prime_eff;
            state_d          = S_MOD2;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_MOD2: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, dstep};
          div_req.divisor  = DIVISOR_W'(size_eff);
          state_d          = S_MOD3;
        end
      end
      S_MOD3: begin
        if (div_done) begin
          inc_d   = div_rem[ADDR_W-1:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (j_q == size_eff) begin
          res_d             = '0;
          res_d.probe_count = j_q;
          res_d.status      = ST_FULL;
          state_d           = S_DONE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!mem_rdata.occupied) begin
          res_d             = '0;
          res_d.slot_index  = pos_q;
          res_d.probe_count = j_q;
          if (action_e'(act_q) == ACT_INSERT) begin
            mem_we               = 1'b1;
            mem_wdata.occupied   = 1'b1;
            mem_wdata.key_length = len_q;
            mem_wdata.key        = key_q;
            mem_wdata.value      = val_q;
            res_d.status         = ST_INSERTED;
          end else begin
            res_d.status = ST_MISSING;
          end
          state_d = S_DONE;
        end else if (mem_rdata.key_length == len_q && mem_rdata.key == key_q) begin
          res_d.slot_index  = pos_q;
          res_d.probe_count = j_q;
          res_d.status      = ST_PRESENT;
          res_d.found_value = mem_rdata.value;
          state_d           = S_DONE;
        end else begin
          j_d = j_q + 1'b1;
          if (pos_sum >= {1'b0, size_eff}) begin
            pos_d = ADDR_W'(pos_sum - {1'b0, size_eff});
          end else begin
            pos_d = pos_sum[ADDR_W-1:0];
          end
          if (pmode == PROBE_QUAD) begin
            if (quad_sum2 >= {1'b0, size_eff}) begin
              inc_d = ADDR_W'(quad_sum2 - {1'b0, size_eff});
            end else begin
              inc_d = quad_sum2[ADDR_W-1:0];
            end
          end
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    key_q   <= key_d;
    len_q   <= len_d;
    val_q   <= val_d;
    acc_q   <= acc_d;
    start_q <= start_d;
    pos_q   <= pos_d;
    inc_q   <= inc_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("slot write while idle");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (j_q < size_eff && {1'b0, pos_q} < size_eff))
    else $error("probe beyond table size");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_CLEARED) |->
      (out_data_o.slot_index == '0 && out_data_o.probe_count == '0 &&
       out_data_o.found_value == '0))
    else $error("clear result not zero");

  a_start_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD && j_q == '0) |-> (pos_q == start_q))
    else $error("first probe not at hash slot");

endmodule
